>>> rtl/amfd_pkg.sv
// Package for the accelerometer motion and up-face detector.
// Holds the mode encoding, face codes, register map and fixed field widths.
// No dependencies; every other file of the block imports it.
package amfd_pkg;

    // Fixed widths of the configuration port and of the non-sample fields
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int TS_W        = 64;
    localparam int THR_W       = 16;
    localparam int TMO_W       = 32;
    localparam int FACE_W      = 3;
    localparam int OUT_TDATA_W = 8;

    // Register reset values
    localparam logic [THR_W-1:0] THR_RESET = 16'd40;
    localparam logic [TMO_W-1:0] TMO_RESET = 32'd2000000;

    // Register index, taken from paddr[2]
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_TIMEOUT   = 1'b1;

    // Face codes, in priority order for ties
    localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd1;
    localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd2;
    localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd3;
    localparam logic [FACE_W-1:0] FACE_POS_X = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd5;
    localparam logic [FACE_W-1:0] FACE_MAX   = FACE_NEG_X;

    // Motion mode, one-hot
    typedef enum logic [2:0] {
        MODE_STILL     = 3'b001,
        MODE_MOVING    = 3'b010,
        MODE_COUNTDOWN = 3'b100
    } mode_t;

    // Result of comparing the squared difference with the squared threshold
    typedef struct packed {
        logic gt;
        logic lt;
    } cmp_t;

endpackage

>>> rtl/amfd_mode_fsm.sv
// Motion mode state machine: still, moving and countdown with a quiet timeout.
// Depends on amfd_pkg for the mode encoding and the compare result struct.
// Advances once per sample on step; moving reflects the mode before the step.
module amfd_mode_fsm
    import amfd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  cmp_t             cmp,
    input  logic [TS_W-1:0]  now_us,
    input  logic [TMO_W-1:0] timeout_us,
    output logic             moving
);

    mode_t            mode_reg;
    mode_t            mode_next;
    logic [TS_W-1:0]  start_reg;
    logic [TS_W-1:0]  start_next;
    logic [TS_W-1:0]  elapsed;
    logic             timed_out;

    // Wrapping time since the countdown began
    assign elapsed   = now_us - start_reg;
    assign timed_out = elapsed > {{(TS_W-TMO_W){1'b0}}, timeout_us};

    // Only still mode reports no motion
    assign moving = (mode_reg != MODE_STILL);

    // Transitions; a difference equal to the threshold counts neither as motion nor as quiet
    always_comb
    begin
        mode_next  = mode_reg;
        start_next = start_reg;
        unique case (mode_reg)
            MODE_STILL:
            begin
                if (cmp.gt)
                begin
                    mode_next = MODE_MOVING;
                end
            end
            MODE_MOVING:
            begin
                if (cmp.lt)
                begin
                    mode_next  = MODE_COUNTDOWN;
                    start_next = now_us;
                end
            end
            MODE_COUNTDOWN:
            begin
                if (cmp.gt)
                begin
                    mode_next = MODE_MOVING;
                end
                else if (timed_out)
                begin
                    mode_next = MODE_STILL;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    // Mode and countdown start registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_MOVING;
            start_reg <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
        end
    end

endmodule

>>> rtl/accel_motion_and_face_detect.sv
// Top level of the accelerometer motion and up-face detector.
// Depends on amfd_pkg and instantiates amfd_mode_fsm.
//
//  Channel  Dir  Beat contents
//  s_*      in   accel_x, accel_y, accel_z (ACCEL_WIDTH each, signed), now_us (64)
//  m_*      out  moving_flag (1), up_face (3)
//  APB      in   threshold_mg at 0x0, timeout_us at 0x4
//
// One beat is accepted per cycle while the output is not stalled. The pipeline
// has an input register, a register after the difference squares, and the
// result register. The mode state advances as a beat leaves the second register.
// Stalls propagate back combinationally through the stage handshakes; empty
// stages keep taking beats while a result waits. Reset clears the previous
// sample, sets the mode to moving and loads the register defaults.
module accel_motion_and_face_detect
    import amfd_pkg::*;
#(
    parameter int ACCEL_WIDTH = 16
)
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    // tdata: accel_x, accel_y, accel_z, now_us, zero fill (lowest first)
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    input  logic [((3*ACCEL_WIDTH+TS_W+7)/8)*8-1:0]       s_tdata,
    // tdata: moving_flag, up_face, zero fill (lowest first)
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    output logic [OUT_TDATA_W-1:0]                        m_tdata,
    input  logic                                          psel,
    input  logic                                          penable,
    input  logic                                          pwrite,
    input  logic [APB_AW-1:0]                             paddr,
    input  logic [APB_DW-1:0]                             pwdata,
    output logic [APB_DW-1:0]                             prdata,
    output logic                                          pready
);

    localparam int W      = ACCEL_WIDTH;
    localparam int SQ_W   = 2 * W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int CMP_W  = (SUM_W > 2 * THR_W) ? SUM_W : 2 * THR_W;

    // Configuration registers
    logic [THR_W-1:0]    threshold_reg;
    logic [TMO_W-1:0]    timeout_reg;
    logic [2*THR_W-1:0]  thr_sq_reg;
    logic                cfg_wr;

    // Previous accepted sample
    logic [W-1:0]        last_reg [3];

    // Stage 1
    logic                v1_reg;
    logic [W-1:0]        cur_reg [3];
    logic [W-1:0]        prv_reg [3];
    logic [TS_W-1:0]     now1_reg;
    logic [SQ_W-1:0]     sq [3];
    logic [FACE_W-1:0]   face;

    // Stage 2
    logic                v2_reg;
    logic [SQ_W-1:0]     sq2_reg [3];
    logic [TS_W-1:0]     now2_reg;
    logic [FACE_W-1:0]   face2_reg;
    logic [SUM_W-1:0]    sum;
    cmp_t                cmp;
    logic                moving;

    // Stage 3 (result)
    logic                v3_reg;
    logic                moving3_reg;
    logic [FACE_W-1:0]   face3_reg;

    logic                rdy1;
    logic                rdy2;
    logic                rdy3;
    logic                s_acc;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THR_RESET;
            timeout_reg   <= TMO_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_THRESHOLD: threshold_reg <= pwdata[THR_W-1:0];
                REG_TIMEOUT:   timeout_reg   <= pwdata[TMO_W-1:0];
                default:       threshold_reg <= threshold_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_THRESHOLD: prdata = {{(APB_DW-THR_W){1'b0}}, threshold_reg};
            REG_TIMEOUT:   prdata = timeout_reg;
            default:       prdata = '0;
        endcase
    end

    // Squared threshold, refreshed every cycle from the register
    always_ff @(posedge clk)
    begin
        thr_sq_reg <= (2*THR_W)'(threshold_reg) * (2*THR_W)'(threshold_reg);
    end

    // Stage handshakes: a stage takes a beat when it is empty or drains
    assign rdy3     = !v3_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign s_acc    = s_tvalid && rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                last_reg[i] <= '0;
            end
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= s_tvalid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (s_acc)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    last_reg[i] <= s_tdata[i*W +: W];
                end
            end
        end
    end

    // Input register: current sample with the one before it
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cur_reg[i] <= s_tdata[i*W +: W];
                prv_reg[i] <= last_reg[i];
            end
            now1_reg <= s_tdata[3*W +: TS_W];
        end
    end

    // Per-axis difference, its magnitude and its square
    for (genvar g = 0; g < 3; g++)
    begin : g_axis
        logic [W:0]   diff;
        logic [W:0]   diff_neg;
        logic [W-1:0] mag;

        assign diff     = {cur_reg[g][W-1], cur_reg[g]} - {prv_reg[g][W-1], prv_reg[g]};
        assign diff_neg = -diff;
        assign mag      = diff[W] ? diff_neg[W-1:0] : diff[W-1:0];
        assign sq[g]    = SQ_W'(mag) * SQ_W'(mag);
    end

    // Up face: first signed axis strictly above the running maximum
    always_comb
    begin
        logic signed [W:0] proj [6];
        logic signed [W:0] best;

        proj[FACE_POS_Z] = $signed({cur_reg[2][W-1], cur_reg[2]});
        proj[FACE_NEG_Z] = -$signed({cur_reg[2][W-1], cur_reg[2]});
        proj[FACE_NEG_Y] = -$signed({cur_reg[1][W-1], cur_reg[1]});
        proj[FACE_POS_Y] = $signed({cur_reg[1][W-1], cur_reg[1]});
        proj[FACE_POS_X] = $signed({cur_reg[0][W-1], cur_reg[0]});
        proj[FACE_NEG_X] = -$signed({cur_reg[0][W-1], cur_reg[0]});
        best = '0;
        face = FACE_POS_Z;
        for (int i = 0; i < 6; i++)
        begin
            if (proj[i] > best)
            begin
                best = proj[i];
                face = FACE_W'(i);
            end
        end
    end

    // Second register: squares, timestamp and face
    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq2_reg[i] <= sq[i];
            end
            now2_reg  <= now1_reg;
            face2_reg <= face;
        end
    end

    // Sum of squares against the squared threshold
    assign sum    = SUM_W'(sq2_reg[0]) + SUM_W'(sq2_reg[1]) + SUM_W'(sq2_reg[2]);
    assign cmp.gt = CMP_W'(sum) > CMP_W'(thr_sq_reg);
    assign cmp.lt = CMP_W'(sum) < CMP_W'(thr_sq_reg);

    amfd_mode_fsm u_mode
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (v2_reg && rdy3),
        .cmp        (cmp),
        .now_us     (now2_reg),
        .timeout_us (timeout_reg),
        .moving     (moving)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            moving3_reg <= moving;
            face3_reg   <= face2_reg;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {{(OUT_TDATA_W-FACE_W-1){1'b0}}, face3_reg, moving3_reg};

endmodule

>>> rtl/amfd_checker.sv
// Port-level checker for the motion and up-face detector, with its bind.
// Depends on amfd_pkg for the register map, face range and port widths.
module amfd_port_checker
    import amfd_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   psel,
    input logic                   penable,
    input logic                   pwrite,
    input logic [APB_AW-1:0]      paddr,
    input logic [APB_DW-1:0]      pwdata,
    input logic [APB_DW-1:0]      prdata,
    input logic                   pready
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // The up face code stays within the six faces
    a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[3:1] <= FACE_MAX)
        else $error("up face code out of range");

    // The configuration port never inserts wait states
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

    // A threshold write reads back, with the upper bits zero
    a_thr_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && paddr[2] == REG_THRESHOLD
        ##1 paddr[2] == REG_THRESHOLD
        |-> prdata[THR_W-1:0] == $past(pwdata[THR_W-1:0])
            && prdata[APB_DW-1:THR_W] == '0)
        else $error("threshold readback mismatch");

endmodule

bind accel_motion_and_face_detect amfd_port_checker u_amfd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
);

>>> tb/amfd_checker.sv
// Checker for the accelerometer motion and up-face detector.
// Watches the sample, result and register channels, predicts each result and compares.
// Depends on amfd_pkg for the mode encoding, face codes and register map.
module amfd_checker
    import amfd_pkg::*;
#(
    parameter int ACCEL_W = 16,
    parameter int S_W     = ((3*ACCEL_W+TS_W+7)/8)*8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_W-1:0]       s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    input  logic [APB_DW-1:0]    prdata,
    input  logic                 pready,
    output int                   mismatches,
    output int                   pending,
    output int                   checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              moving;
        logic [FACE_W-1:0] face;
    } flag_face_t;

    // Shadow of the detector: registers, previous sample, mode and countdown start
    logic [THR_W-1:0]  thr_mg;
    logic [TMO_W-1:0]  tmo_us;
    int                prev_x;
    int                prev_y;
    int                prev_z;
    mode_t             mode;
    logic [TS_W-1:0]   quiet_since;

    flag_face_t        flag_face_queue[$];

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR at %0t ns: %s, got 0x%0h, wanted 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // Advances the shadow state by one sample beat and returns the flag and face.
    function automatic flag_face_t step_motion_face(input logic [S_W-1:0] beat);
        int          ax;
        int          ay;
        int          az;
        longint      dx;
        longint      dy;
        longint      dz;
        longint      sq_sum;
        longint      thr_sq;
        logic        gt;
        logic        lt;
        int          best;
        logic [TS_W-1:0] now;
        flag_face_t  res;
        begin
            ax  = $signed(beat[ACCEL_W-1:0]);
            ay  = $signed(beat[2*ACCEL_W-1:ACCEL_W]);
            az  = $signed(beat[3*ACCEL_W-1:2*ACCEL_W]);
            now = beat[3*ACCEL_W+TS_W-1:3*ACCEL_W];

            // Exact magnitude compare through squares
            dx = ax - prev_x;
            dy = ay - prev_y;
            dz = az - prev_z;
            sq_sum = dx*dx + dy*dy + dz*dz;
            thr_sq = longint'(thr_mg) * longint'(thr_mg);
            gt = (sq_sum > thr_sq);
            lt = (sq_sum < thr_sq);
            prev_x = ax;
            prev_y = ay;
            prev_z = az;

            // Up face: first strictly larger projection wins, nothing positive means +z
            best = 0;
            res.face = FACE_POS_Z;
            if (az > best)  begin best = az;  res.face = FACE_POS_Z; end
            if (-az > best) begin best = -az; res.face = FACE_NEG_Z; end
            if (-ay > best) begin best = -ay; res.face = FACE_NEG_Y; end
            if (ay > best)  begin best = ay;  res.face = FACE_POS_Y; end
            if (ax > best)  begin best = ax;  res.face = FACE_POS_X; end
            if (-ax > best) begin best = -ax; res.face = FACE_NEG_X; end

            // The flag reflects the mode held before this sample
            res.moving = 1'b1;
            case (mode)
                MODE_STILL:
                begin
                    res.moving = 1'b0;
                    if (gt)
                        mode = MODE_MOVING;
                end
                MODE_MOVING:
                begin
                    if (lt)
                    begin
                        quiet_since = now;
                        mode = MODE_COUNTDOWN;
                    end
                end
                MODE_COUNTDOWN:
                begin
                    if (gt)
                        mode = MODE_MOVING;
                    else if (now - quiet_since > {32'd0, tmo_us})
                        mode = MODE_STILL;
                end
                default:
                begin
                end
            endcase
            return res;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        flag_face_t want;
        logic [APB_DW-1:0] reg_val;
        if (!rst_n)
        begin
            thr_mg      = THR_RESET;
            tmo_us      = TMO_RESET;
            prev_x      = 0;
            prev_y      = 0;
            prev_z      = 0;
            mode        = MODE_MOVING;
            quiet_since = '0;
            flag_face_queue.delete();
            pending     = 0;
        end
        else
        begin
            // Register writes and read-back
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[2] == REG_THRESHOLD)
                        thr_mg = pwdata[THR_W-1:0];
                    else
                        tmo_us = pwdata[TMO_W-1:0];
                end
                else
                begin
                    reg_val = (paddr[2] == REG_TIMEOUT) ? tmo_us : {16'd0, thr_mg};
                    if (prdata !== reg_val)
                        report_mismatch("register read-back", prdata, reg_val);
                end
            end

            // Accepted sample beat
            if (s_tvalid && s_tready)
            begin
                flag_face_queue.push_back(step_motion_face(s_tdata));
                pending++;
            end

            // Accepted result beat against the oldest expectation
            if (m_tvalid && m_tready)
            begin
                checked++;
                if (flag_face_queue.size() == 0)
                    report_mismatch("result beat with nothing expected", m_tdata, 0);
                else
                begin
                    want = flag_face_queue.pop_front();
                    pending--;
                    if (m_tdata[0] !== want.moving)
                        report_mismatch("moving_flag", m_tdata[0], want.moving);
                    if (m_tdata[FACE_W:1] !== want.face)
                        report_mismatch("up_face", m_tdata[FACE_W:1], want.face);
                    if (m_tdata[OUT_TDATA_W-1:FACE_W+1] !== '0)
                        report_mismatch("zero fill", m_tdata[OUT_TDATA_W-1:FACE_W+1], 0);
                end
            end
        end
    end

    initial
    begin
        mismatches = 0;
        pending    = 0;
        checked    = 0;
    end

endmodule

>>> tb/tb.sv
// Top of the testbench for the accelerometer motion and up-face detector.
// Drives samples, registers and result back-pressure; the checker does the comparing.
// Depends on amfd_pkg, accel_motion_and_face_detect and amfd_checker.
module tb
    import amfd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ACCEL_W      = 16;
    localparam int S_W          = ((3*ACCEL_W+TS_W+7)/8)*8;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int PHASES       = 5;
    localparam int PHASE_BEATS  = 350;
    localparam logic [APB_AW-1:0] ADDR_THRESHOLD = {REG_THRESHOLD, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_TIMEOUT   = {REG_TIMEOUT, 2'b00};

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    // tdata: accel_x, accel_y, accel_z, now_us (lowest first)
    logic [S_W-1:0]         s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    // tdata: moving_flag, up_face, zero fill (lowest first)
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_AW-1:0]      paddr;
    logic [APB_DW-1:0]      pwdata;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    int                     mismatches;
    int                     pending;
    int                     checked;
    int                     cycles = 0;
    int                     sent = 0;
    logic                   steady;

    // Stimulus state: running sample, timestamp and current register values
    int                     cur_x;
    int                     cur_y;
    int                     cur_z;
    logic [TS_W-1:0]        now_t;
    logic [THR_W-1:0]       thr_cur;
    logic [TMO_W-1:0]       tmo_cur;
    logic [THR_W-1:0]       thr_set [PHASES];
    logic [TMO_W-1:0]       tmo_set [PHASES];

    accel_motion_and_face_detect #(.ACCEL_WIDTH(ACCEL_W)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    amfd_checker #(.ACCEL_W(ACCEL_W)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycles, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long, none in a steady stretch.
    function automatic int pick_gap();
        int r;
        begin
            if (steady)
                return 0;
            r = $urandom_range(0, 99);
            if (r < 60)
                return 0;
            if (r < 90)
                return $urandom_range(1, 3);
            return $urandom_range(10, 40);
        end
    endfunction

    function automatic int clamp_mg(input int v);
        begin
            if (v > 32767)
                return 32767;
            if (v < -32768)
                return -32768;
            return v;
        end
    endfunction

    function automatic int walk_step(input int span);
        begin
            if ($urandom_range(0, 3) == 0)
                return 0;
            return int'($urandom_range(0, 2*span)) - span;
        end
    endfunction

    // Offers one sample beat, holds it until accepted, then maybe idles.
    task automatic send_beat(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z, input logic [63:0] now);
        int gap;
        begin
            s_tvalid <= 1'b1;
            s_tdata  <= S_W'({now, z, y, x});
            do
                @(posedge clk);
            while (!s_tready);
            sent++;
            @(negedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic stop_sender();
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        begin
            while (pending != 0)
                @(negedge clk);
        end
    endtask

    // One APB transfer: setup phase, access phase, then a return to idle.
    task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                              input logic [APB_DW-1:0] data);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= wr;
            paddr   <= addr;
            pwdata  <= data;
            @(negedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            @(negedge clk);
        end
    endtask

    // Result side back-pressure.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
        end
    end

    initial
    begin
        int ph;
        int n;
        int r;
        int span;
        int axis;
        int k;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        steady   = 1'b0;
        rst_n    = 1'b0;
        cur_x    = 0;
        cur_y    = 0;
        cur_z    = 0;
        now_t    = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset values of both registers
        apb_access(1'b0, ADDR_THRESHOLD, '0);
        apb_access(1'b0, ADDR_TIMEOUT, '0);

        // Directed samples under the reset registers.
        // Quiet sample drops moving into countdown; a difference equal to the
        // threshold holds the mode.
        send_beat(16'sd0, 16'sd0, 16'sd0, 64'd100);
        send_beat(16'sd40, 16'sd0, 16'sd0, 64'd200);
        send_beat(16'sd0, 16'sd0, 16'sd0, 64'd300);
        // Quiet time equal to the timeout holds, one more microsecond goes still.
        send_beat(16'sd0, 16'sd0, 16'sd0, 64'd100 + TMO_RESET);
        send_beat(16'sd0, 16'sd0, 16'sd0, 64'd101 + TMO_RESET);
        // Still mode: small difference, then a difference equal to the threshold.
        send_beat(16'sd10, 16'sd0, -16'sd7, 64'd2100200);
        send_beat(16'sd10, 16'sd40, -16'sd7, 64'd2100300);
        // Full-scale swings; ties between faces keep the earlier one.
        send_beat(16'h8000, 16'h7FFF, 16'h8000, 64'd0);
        send_beat(16'h7FFF, 16'h8000, 16'h7FFF, 64'hFFFF_FFFF_FFFF_FFFF);
        // Countdown started just before the timestamp wraps.
        send_beat(16'h7FFF, 16'h8000, 16'h7FFF, 64'hFFFF_FFFF_FFFF_FFF0);
        send_beat(16'h7FFF, 16'h8000, 16'h7FFF, 64'd5);
        send_beat(16'h7FFF, 16'h8000, 16'h7FFF, 64'd1999984);
        send_beat(16'h7FFF, 16'h8000, 16'h7FFF, 64'd1999985);
        // Each face on its own, and no positive projection at all.
        send_beat(16'sd5, 16'sd5, 16'sd5, 64'd2000000);
        send_beat(16'sd0, 16'sd7, 16'sd0, 64'd2000010);
        send_beat(16'sd0, -16'sd7, 16'sd0, 64'd2000020);
        send_beat(16'sd7, 16'sd0, 16'sd0, 64'd2000030);
        send_beat(-16'sd7, 16'sd0, 16'sd0, 64'd2000040);
        send_beat(16'sd0, 16'sd0, -16'sd7, 64'd2000050);
        send_beat(16'sd0, 16'sd0, 16'sd0, 64'd2000060);
        // Off-axis difference exactly on the threshold, then one step past it.
        send_beat(16'sd24, 16'sd32, 16'sd0, 64'd2000070);
        send_beat(16'sd0, 16'sd0, 16'sd0, 64'd2000080);
        send_beat(16'sd24, 16'sd32, 16'sd1, 64'd2000090);
        now_t = 64'd2000100;

        thr_set[0] = 16'd0;     tmo_set[0] = 32'd0;
        thr_set[1] = 16'hFFFF;  tmo_set[1] = 32'hFFFF_FFFF;
        thr_set[2] = THR_W'($urandom_range(1, 2000));
        tmo_set[2] = $urandom_range(1, 100000);
        thr_set[3] = THR_RESET; tmo_set[3] = TMO_RESET;
        thr_set[4] = 16'd3;     tmo_set[4] = 32'd50;

        for (ph = 0; ph < PHASES; ph++)
        begin
            // Registers change only with the pipeline empty
            stop_sender();
            wait_drained();
            repeat (4) @(negedge clk);
            thr_cur = thr_set[ph];
            tmo_cur = tmo_set[ph];
            apb_access(1'b1, ADDR_THRESHOLD, {16'($urandom), thr_cur});
            apb_access(1'b1, ADDR_TIMEOUT, tmo_cur);
            apb_access(1'b0, ADDR_THRESHOLD, '0);
            apb_access(1'b0, ADDR_TIMEOUT, '0);

            for (n = 0; n < PHASE_BEATS; n++)
            begin
                if (n == 120)
                begin
                    stop_sender();
                    wait_drained();
                end
                steady = (n >= 200 && n < 260);
                r = $urandom_range(0, 99);
                if (r < 75)
                begin
                    // Walk around the previous sample at the scale of the threshold
                    span = 2*int'(thr_cur) + 2;
                    if ($urandom_range(0, 9) == 0)
                    begin
                        axis = $urandom_range(0, 2);
                        k = $urandom_range(0, 1) ? int'(thr_cur) : -int'(thr_cur);
                        if (axis == 0)
                            cur_x = clamp_mg(cur_x + k);
                        else if (axis == 1)
                            cur_y = clamp_mg(cur_y + k);
                        else
                            cur_z = clamp_mg(cur_z + k);
                    end
                    else
                    begin
                        cur_x = clamp_mg(cur_x + walk_step(span));
                        cur_y = clamp_mg(cur_y + walk_step(span));
                        cur_z = clamp_mg(cur_z + walk_step(span));
                    end
                    k = $urandom_range(0, 9);
                    if (k < 4)
                        now_t = now_t + $urandom_range(0, tmo_cur / 4);
                    else if (k == 4)
                        now_t = now_t + tmo_cur;
                    else if (k == 5)
                        now_t = now_t + tmo_cur + 64'd1;
                    else if (k == 7)
                        now_t = now_t + TS_W'(tmo_cur - 32'd1);
                    else if (k > 7)
                        now_t = now_t + $urandom_range(0, 1000);
                end
                else
                begin
                    // Noise: full-range samples and arbitrary timestamps
                    cur_x = $signed(16'($urandom));
                    cur_y = $signed(16'($urandom));
                    cur_z = $signed(16'($urandom));
                    if ($urandom_range(0, 1))
                        now_t = {$urandom, $urandom};
                end
                send_beat(16'(cur_x), 16'(cur_y), 16'(cur_z), now_t);
            end
        end
        steady = 1'b0;

        stop_sender();
        wait_drained();
        repeat (20) @(posedge clk);

        $display("Covered %0d sample beats over %0d register settings, reset values included.",
                 sent, PHASES + 1);
        $display("Compared %0d result beats in %0d cycles; %0d mismatches.",
                 checked, cycles, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
